// File: hw/rtl/pee_pkg.sv
// Package for the prefix expression evaluator.
// Holds the stack and value sizes, symbol codes, status codes, sequencer states
// and the magnitude helper. It has no dependencies.
package pee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int ITER_W      = $clog2(VALUE_WIDTH);
    localparam int SYM_W       = 8;
    localparam int DEPTH_W     = 8;
    localparam int TOP_W       = 32;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK,
        ST_UNDERFLOW,
        ST_OVERFLOW,
        ST_DIV_ZERO
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_WRITE,
        S_OUT
    } state_t;

    function automatic logic [VALUE_WIDTH-1:0] mag(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] m;
        m = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

endpackage

// File: hw/rtl/prefix_expression_evaluator_core.sv
// Top level of the prefix expression evaluator.
// Holds the operand stack memory, the sequencer and the iterative divider.
// Depends on pee_pkg.

// Characters of a prefix expression arrive right to left, one transfer each, and
// every character gives one result transfer carrying the top of stack, the depth
// and a status. The input is stalled until the result register has taken the
// character's result. A digit, an ignored character, an underflow or an overflow
// passes through decode and output; a division by zero also reads the stack;
// add, subtract and multiply read the stack and write the result back; division
// runs the restoring divider between read and write-back, which retires one
// quotient bit per cycle. The result register is loaded in the cycle before
// the next character can be accepted. The second operand comes from
// a single-port stack memory with a registered read, while the top of stack is
// held in a register. No new character is accepted while one is being worked on,
// but one may be accepted while the previous result still waits in the output
// register. The stack memory needs no clearing after reset.
module prefix_expression_evaluator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pee_pkg::SYM_W-1:0]   symbol,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [pee_pkg::TOP_W-1:0] top_value,
    output logic [pee_pkg::DEPTH_W-1:0] depth,
    output logic [1:0]                  status
);
    import pee_pkg::*;

    state_t                 state_reg,   state_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]       sym_reg,     sym_next;
    status_t                status_reg,  status_next;
    logic [VALUE_WIDTH-1:0] top_reg,     top_next;
    logic [VALUE_WIDTH-1:0] res_reg,     res_next;
    logic [VALUE_WIDTH-1:0] rem_reg,     rem_next;
    logic [VALUE_WIDTH-1:0] dsr_reg,     dsr_next;
    logic                   neg_reg,     neg_next;
    logic [ITER_W-1:0]      iter_reg,    iter_next;
    logic [TOP_W-1:0]       otop_reg,    otop_next;
    logic [DEPTH_W-1:0]     odepth_reg,  odepth_next;
    status_t                ostatus_reg, ostatus_next;

    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    logic [CNT_W-1:0]         count_m2;
    logic [3:0]               digit;
    logic                     is_digit;
    logic                     is_op;
    logic [VALUE_WIDTH-1:0]   product;
    logic [VALUE_WIDTH:0]     rem_shift;
    logic [VALUE_WIDTH:0]     rem_trial;
    logic [VALUE_WIDTH-1:0]   result;

    assign count_m2  = count_reg - CNT_W'(2);
    assign digit     = 4'(sym_reg - SYM_ZERO);
    assign is_digit  = (sym_reg >= SYM_ZERO) && (sym_reg <= SYM_NINE);
    assign is_op     = (sym_reg == SYM_PLUS) || (sym_reg == SYM_MINUS) ||
                       (sym_reg == SYM_MUL) || (sym_reg == SYM_DIV);
    assign product   = top_reg * rd_data_reg;
    assign rem_shift = {rem_reg, res_reg[VALUE_WIDTH-1]};
    assign rem_trial = rem_shift - {1'b0, dsr_reg};
    assign result    = ((sym_reg == SYM_DIV) && neg_reg) ? (~res_reg + 1'b1) : res_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign top_value = otop_reg;
    assign depth     = odepth_reg;
    assign status    = ostatus_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        sym_next       = sym_reg;
        status_next    = status_reg;
        top_next       = top_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        neg_next       = neg_reg;
        iter_next      = iter_reg;
        otop_next      = otop_reg;
        odepth_next    = odepth_reg;
        ostatus_next   = ostatus_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next    = symbol;
                    count_next  = restart ? '0 : count_reg;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                if (is_digit)
                begin
                    if (count_reg == CNT_W'(STACK_DEPTH))
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[ADDR_W-1:0];
                        mem_wdata  = VALUE_WIDTH'(digit);
                        top_next   = VALUE_WIDTH'(digit);
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (is_op)
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = count_m2[ADDR_W-1:0];
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
                case (sym_reg)
                    SYM_PLUS:  res_next = top_reg + rd_data_reg;
                    SYM_MINUS: res_next = top_reg - rd_data_reg;
                    SYM_MUL:   res_next = product;
                    default:
                    begin
                        if (rd_data_reg == '0)
                        begin
                            status_next = ST_DIV_ZERO;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            rem_next   = '0;
                            res_next   = mag(top_reg);
                            dsr_next   = mag(rd_data_reg);
                            neg_next   = top_reg[VALUE_WIDTH-1] ^ rd_data_reg[VALUE_WIDTH-1];
                            iter_next  = ITER_W'(VALUE_WIDTH - 1);
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (!rem_trial[VALUE_WIDTH])
                begin
                    rem_next = rem_trial[VALUE_WIDTH-1:0];
                    res_next = {res_reg[VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[VALUE_WIDTH-1:0];
                    res_next = {res_reg[VALUE_WIDTH-2:0], 1'b0};
                end
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_m2[ADDR_W-1:0];
                mem_wdata  = result;
                top_next   = result;
                count_next = count_reg - 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    otop_next      = (count_reg == '0) ? '0 : TOP_W'(top_reg);
                    odepth_next    = DEPTH_W'(count_reg);
                    ostatus_next   = status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        status_reg  <= status_next;
        top_reg     <= top_next;
        res_reg     <= res_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        neg_reg     <= neg_next;
        iter_reg    <= iter_next;
        otop_reg    <= otop_next;
        odepth_reg  <= odepth_next;
        ostatus_reg <= ostatus_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/pee_checker.sv
// Port-level checker for the prefix expression evaluator, bound to its top level.
// Depends on pee_pkg and on prefix_expression_evaluator_core.
module pee_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [pee_pkg::TOP_W-1:0] top_value,
    input logic [pee_pkg::DEPTH_W-1:0] depth,
    input logic [1:0]                  status
);
    import pee_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> depth <= DEPTH_W'(STACK_DEPTH))
        else $error("Depth exceeds the stack size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && depth == '0) |-> top_value == '0)
        else $error("Empty stack reports a non-zero top value.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> depth == DEPTH_W'(STACK_DEPTH))
        else $error("Overflow reported on a stack that is not full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |-> depth < DEPTH_W'(2))
        else $error("Underflow reported with two or more entries.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(top_value) && $stable(depth) && $stable(status)))
        else $error("Stalled result transfer changed.");

endmodule

bind prefix_expression_evaluator_core pee_checker u_pee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .top_value (top_value),
    .depth     (depth),
    .status    (status)
);

// File: bench/tb.sv
// Self-checking testbench for the prefix expression evaluator core.
// It predicts every result transfer with its own operand stack and checks it field by field.
// Depends on pee_pkg and prefix_expression_evaluator_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pee_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [TOP_W-1:0] top_value;
        logic [DEPTH_W-1:0]      depth;
        status_t                 status;
    } result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [SYM_W-1:0]        symbol;
    logic                    restart;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [TOP_W-1:0] top_value;
    logic [DEPTH_W-1:0]      depth;
    logic [1:0]              status;

    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
    int                     stack_fill = 0;
    result_t                pending_results [$];
    result_t                wanted_result;
    int                     error_count = 0;
    int                     counted_items = 0;
    int                     quiet_cycles = 0;
    bit                     sender_idling = 1'b1;
    bit                     receiver_idling = 1'b1;
    bit                     hold_receiver = 1'b0;

    prefix_expression_evaluator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .symbol    (symbol),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .top_value (top_value),
        .depth     (depth),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic result_t evaluate_symbol(input logic [SYM_W-1:0] sym, input logic clear);
        result_t                res;
        logic [VALUE_WIDTH-1:0] lhs;
        logic [VALUE_WIDTH-1:0] rhs;
        logic [VALUE_WIDTH-1:0] lhs_mag;
        logic [VALUE_WIDTH-1:0] rhs_mag;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [VALUE_WIDTH-1:0] outcome;
        res.status = ST_OK;
        if (clear)
            stack_fill = 0;
        if (sym >= SYM_ZERO && sym <= SYM_NINE)
        begin
            if (stack_fill >= STACK_DEPTH)
                res.status = ST_OVERFLOW;
            else
            begin
                stack_mem[stack_fill] = VALUE_WIDTH'(sym - SYM_ZERO);
                stack_fill++;
            end
        end
        else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_MUL || sym == SYM_DIV)
        begin
            if (stack_fill < 2)
                res.status = ST_UNDERFLOW;
            else
            begin
                lhs = stack_mem[stack_fill - 1];
                rhs = stack_mem[stack_fill - 2];
                outcome = '0;
                case (sym)
                    SYM_PLUS:  outcome = lhs + rhs;
                    SYM_MINUS: outcome = lhs - rhs;
                    SYM_MUL:   outcome = lhs * rhs;
                    default:
                    begin
                        if (rhs == '0)
                            res.status = ST_DIV_ZERO;
                        else
                        begin
                            lhs_mag = lhs[VALUE_WIDTH-1] ? -lhs : lhs;
                            rhs_mag = rhs[VALUE_WIDTH-1] ? -rhs : rhs;
                            quotient = lhs_mag / rhs_mag;
                            outcome = (lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1]) ? -quotient
                                                                                  : quotient;
                        end
                    end
                endcase
                if (res.status == ST_OK)
                begin
                    stack_fill--;
                    stack_mem[stack_fill - 1] = outcome;
                end
            end
        end
        res.top_value = (stack_fill == 0) ? '0 : stack_mem[stack_fill - 1];
        res.depth = DEPTH_W'(stack_fill);
        return res;
    endfunction

    function automatic logic [SYM_W-1:0] random_digit();
        return SYM_ZERO + SYM_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return SYM_PLUS;
            1:       return SYM_MINUS;
            2:       return SYM_MUL;
            default: return SYM_DIV;
        endcase
    endfunction

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic clear);
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        restart  <= clear;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(evaluate_symbol(sym, clear));
        counted_items++;
    endtask

    task automatic test_directed_cases();
        send_symbol(SYM_PLUS, 1'b1);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(SYM_NINE + 8'd1, 1'b0);
        send_symbol(SYM_PLUS + 8'd1, 1'b0);
        send_symbol(SYM_MINUS + 8'd1, 1'b0);
        send_symbol(SYM_ZERO, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_ZERO + 8'd7, 1'b0);
        send_symbol(SYM_DIV, 1'b0);
        send_symbol(SYM_NINE, 1'b0);
        send_symbol(SYM_MUL, 1'b0);
        send_symbol(SYM_PLUS, 1'b0);
        send_symbol(SYM_ZERO + 8'd2, 1'b0);
        send_symbol(SYM_NINE, 1'b0);
        send_symbol(SYM_ZERO + 8'd2, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_DIV, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_NINE, 1'b1);
        send_symbol(8'h20, 1'b1);
    endtask

    // Builds minus one beneath two to the power 31, which wraps to the most negative value,
    // and then divides the two.
    task automatic test_most_negative_quotient();
        int k;
        send_symbol(SYM_ZERO + 8'd1, 1'b1);
        send_symbol(SYM_ZERO, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_ZERO + 8'd8, 1'b0);
        for (k = 0; k < 9; k++)
        begin
            send_symbol(SYM_ZERO + 8'd8, 1'b0);
            send_symbol(SYM_MUL, 1'b0);
        end
        send_symbol(SYM_ZERO + 8'd2, 1'b0);
        send_symbol(SYM_MUL, 1'b0);
        send_symbol(SYM_DIV, 1'b0);
    endtask

    task automatic test_stack_full();
        int k;
        send_symbol(random_digit(), 1'b1);
        for (k = 1; k < STACK_DEPTH; k++)
            send_symbol(random_digit(), 1'b0);
        repeat (3) send_symbol(random_digit(), 1'b0);
        send_symbol(random_operator(), 1'b0);
        repeat (2) send_symbol(random_digit(), 1'b0);
        send_symbol(random_digit(), 1'b1);
    endtask

    task automatic test_output_hold();
        int k;
        sender_idling = 1'b0;
        hold_receiver = 1'b1;
        send_symbol(random_digit(), 1'b1);
        for (k = 0; k < 15; k++)
            send_symbol(($urandom_range(0, 2) == 0) ? random_operator() : random_digit(), 1'b0);
        wait (!hold_receiver);
        sender_idling = 1'b1;
    endtask

    task automatic send_random_expression();
        int   operands_left;
        int   live;
        logic clear;
        operands_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        live = 0;
        clear = ($urandom_range(0, 3) != 0);
        while (operands_left > 0 || live > 1)
        begin
            if ($urandom_range(0, 11) == 0)
                send_symbol(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            else if (operands_left > 0 && (live < 2 || $urandom_range(0, 1) == 0))
            begin
                send_symbol(random_digit(), clear);
                clear = 1'b0;
                operands_left--;
                live++;
            end
            else
            begin
                send_symbol(random_operator(), clear);
                clear = 1'b0;
                live--;
            end
        end
        if ($urandom_range(0, 7) == 0)
            send_symbol(random_operator(), 1'b0);
    endtask

    task automatic test_random_expressions();
        while (counted_items < 650)
            send_random_expression();
    endtask

    task automatic test_back_to_back();
        sender_idling = 1'b0;
        receiver_idling = 1'b0;
        while (counted_items < 750)
            send_random_expression();
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_receiver = 1'b0;
            end
            else if (receiver_idling && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Result transfer with nothing pending: top_value %0d, depth %0d, status %0d",
                       top_value, depth, status);
                error_count++;
            end
            else
            begin
                wanted_result = pending_results.pop_front();
                if (top_value !== wanted_result.top_value)
                begin
                    $error("top_value mismatch: expected %0d, actual %0d",
                           wanted_result.top_value, top_value);
                    error_count++;
                end
                if (depth !== wanted_result.depth)
                begin
                    $error("depth mismatch: expected %0d, actual %0d", wanted_result.depth, depth);
                    error_count++;
                end
                if (status !== wanted_result.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", wanted_result.status,
                           status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        in_valid <= 1'b0;
        symbol   <= '0;
        restart  <= 1'b0;
        rst_n    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_most_negative_quotient();
        test_stack_full();
        test_output_hold();
        test_random_expressions();
        test_back_to_back();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
